@@ rtl/gbp_pkg.sv @@
// Package for the Goldbach pair search: microcode format, program ROM and status codes.
package gbp_pkg;

   // Result status codes
   localparam logic [1:0] STATUS_FOUND     = 2'd0;
   localparam logic [1:0] STATUS_BAD_INPUT = 2'd1;
   localparam logic [1:0] STATUS_NO_PAIR   = 2'd2;

   typedef logic [3:0] step_type;
   typedef logic [3:0] op_type;
   typedef logic [3:0] cond_type;

   // Datapath operations, one per control word
   localparam op_type OP_NOP       = 4'd0;
   localparam op_type OP_LOAD_N    = 4'd1;  // capture input, p = 2, clear result primes
   localparam op_type OP_SET_BAD   = 4'd2;  // status = bad input
   localparam op_type OP_START_P   = 4'd3;  // v = p, d = 2, sq = 4, status = no pair
   localparam op_type OP_DIV_GO    = 4'd4;  // launch v % d
   localparam op_type OP_NEXT_D    = 4'd5;  // d += 1, sq += 2d + 1
   localparam op_type OP_START_Q   = 4'd6;  // v = n - p, d = 2, sq = 4
   localparam op_type OP_INC_P     = 4'd7;  // p += 1
   localparam op_type OP_SET_FOUND = 4'd8;  // record the pair
   localparam op_type OP_EMIT      = 4'd9;  // move result to output register

   // Jump conditions
   localparam cond_type C_NEVER    = 4'd0;
   localparam cond_type C_ALWAYS   = 4'd1;
   localparam cond_type C_NO_REQ   = 4'd2;
   localparam cond_type C_BAD_IN   = 4'd3;
   localparam cond_type C_P_OVER   = 4'd4;
   localparam cond_type C_SQ_OVER  = 4'd5;
   localparam cond_type C_DIV_BUSY = 4'd6;
   localparam cond_type C_REM_ZERO = 4'd7;
   localparam cond_type C_RSP_FULL = 4'd8;

   // Program steps
   localparam step_type S_ACCEPT = 4'd0;
   localparam step_type S_CHECK  = 4'd1;
   localparam step_type S_PTOP   = 4'd2;
   localparam step_type S_TEST1  = 4'd3;
   localparam step_type S_WAIT1  = 4'd4;
   localparam step_type S_DIV1   = 4'd5;
   localparam step_type S_LOOP1  = 4'd6;
   localparam step_type S_SECOND = 4'd7;
   localparam step_type S_TEST2  = 4'd8;
   localparam step_type S_WAIT2  = 4'd9;
   localparam step_type S_DIV2   = 4'd10;
   localparam step_type S_LOOP2  = 4'd11;
   localparam step_type S_NEXT_P = 4'd12;
   localparam step_type S_FOUND  = 4'd13;
   localparam step_type S_EMIT   = 4'd14;
   localparam step_type S_DONE   = 4'd15;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
   } ctrl_word_type;

   // Program ROM: jump to target when cond holds, else fall through
   function automatic ctrl_word_type gbp_rom(input step_type step);
      ctrl_word_type cw;
      case (step)
         S_ACCEPT: cw = '{OP_LOAD_N,    C_NO_REQ,   S_ACCEPT};
         S_CHECK:  cw = '{OP_SET_BAD,   C_BAD_IN,   S_EMIT};
         S_PTOP:   cw = '{OP_START_P,   C_P_OVER,   S_EMIT};
         S_TEST1:  cw = '{OP_DIV_GO,    C_SQ_OVER,  S_SECOND};
         S_WAIT1:  cw = '{OP_NOP,       C_DIV_BUSY, S_WAIT1};
         S_DIV1:   cw = '{OP_NEXT_D,    C_REM_ZERO, S_NEXT_P};
         S_LOOP1:  cw = '{OP_NOP,       C_ALWAYS,   S_TEST1};
         S_SECOND: cw = '{OP_START_Q,   C_NEVER,    S_ACCEPT};
         S_TEST2:  cw = '{OP_DIV_GO,    C_SQ_OVER,  S_FOUND};
         S_WAIT2:  cw = '{OP_NOP,       C_DIV_BUSY, S_WAIT2};
         S_DIV2:   cw = '{OP_NEXT_D,    C_REM_ZERO, S_NEXT_P};
         S_LOOP2:  cw = '{OP_NOP,       C_ALWAYS,   S_TEST2};
         S_NEXT_P: cw = '{OP_INC_P,     C_ALWAYS,   S_PTOP};
         S_FOUND:  cw = '{OP_SET_FOUND, C_NEVER,    S_ACCEPT};
         S_EMIT:   cw = '{OP_EMIT,      C_RSP_FULL, S_EMIT};
         S_DONE:   cw = '{OP_NOP,       C_ALWAYS,   S_ACCEPT};
         default:  cw = '{OP_NOP,       C_ALWAYS,   S_ACCEPT};
      endcase
      return cw;
   endfunction

endpackage

@@ rtl/gbp_divider.sv @@
// Restoring remainder unit: one quotient bit per cycle.
module gbp_divider #(
   parameter int VALUE_WIDTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [VALUE_WIDTH-1:0] dividend,
   input  logic [VALUE_WIDTH-1:0] divisor,
   output logic                   busy,
   output logic [VALUE_WIDTH-1:0] remainder
);
   localparam int CW = $clog2(VALUE_WIDTH + 1);

   logic [CW-1:0]          count_ff, count_in;
   logic [VALUE_WIDTH-1:0] rem_ff, rem_in;
   logic [VALUE_WIDTH-1:0] quo_ff, quo_in;
   logic [VALUE_WIDTH:0]   trial;
   logic [VALUE_WIDTH:0]   diff;

   // One shift-subtract step
   always_comb begin
      trial    = {rem_ff, quo_ff[VALUE_WIDTH-1]};
      diff     = trial - {1'b0, divisor};
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      if (start) begin
         count_in = CW'(VALUE_WIDTH);
         rem_in   = '0;
         quo_in   = dividend;
      end else if (count_ff != '0) begin
         count_in = count_ff - 1'b1;
         quo_in   = {quo_ff[VALUE_WIDTH-2:0], 1'b0};
         if (trial >= {1'b0, divisor}) begin
            rem_in = diff[VALUE_WIDTH-1:0];
         end else begin
            rem_in = trial[VALUE_WIDTH-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign busy      = (count_ff != '0);
   assign remainder = rem_ff;

   // Remainder stays below a nonzero divisor once a division completes
   assert property (@(posedge clock) disable iff (reset)
      $fell(busy) && (divisor != '0) |-> rem_ff < divisor)
      else $error("remainder not below divisor");

   // Start loads the bit counter with VALUE_WIDTH
   assert property (@(posedge clock) disable iff (reset)
      start |=> count_ff == CW'(VALUE_WIDTH))
      else $error("divider count not loaded");

   // Bit counter never exceeds the width
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(VALUE_WIDTH))
      else $error("divider count out of range");

endmodule

@@ rtl/goldbach_prime_pair_search_top.sv @@
// Goldbach pair search: microcoded sequencer over a trial-division datapath.
//
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/req_stall | even_value[15:0]
//  rsp     | out       | rsp_valid/rsp_stall | small_prime[14:0], large_prime[15:0], status[1:0]
//
// One item at a time. Rejected input goes from the check step straight to the emit step.
// Otherwise each candidate p starts at the PTOP step and runs the test, wait and divide steps
// for each trial divisor of p and, once p proves prime, of n - p (shared remainder unit).
// Synchronous reset returns the sequencer to the accept step; no clearing pass.
// A new item is accepted while an earlier result waits in the output register;
// the result of the next item waits in the sequencer until rsp_stall drops.
module goldbach_prime_pair_search_top #(
   parameter int VALUE_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_even_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [14:0] rsp_small_prime,
   output logic [15:0] rsp_large_prime,
   output logic [1:0]  rsp_status
);
   import gbp_pkg::*;

   localparam int W = VALUE_WIDTH;

   ctrl_word_type cw;
   logic          take;

   step_type      pc_ff, pc_in;
   logic [W-1:0]  n_ff, n_in;
   logic [W-1:0]  p_ff, p_in;
   logic [W-1:0]  v_ff, v_in;
   logic [W-1:0]  d_ff, d_in;
   logic [W:0]    sq_ff, sq_in;
   logic [W-1:0]  res_small_ff, res_small_in;
   logic [W-1:0]  res_large_ff, res_large_in;
   logic [1:0]    res_status_ff, res_status_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [14:0]   rsp_small_ff, rsp_small_in;
   logic [15:0]   rsp_large_ff, rsp_large_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;

   logic          div_start;
   logic          div_busy;
   logic [W-1:0]  div_rem;

   logic          bad_in;
   logic          p_over;
   logic          sq_over;
   logic          rsp_full;
   logic [W-1:0]  n_minus_p;

   // Remainder unit shared by both primality tests
   gbp_divider #(.VALUE_WIDTH(W)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (v_ff),
      .divisor   (d_ff),
      .busy      (div_busy),
      .remainder (div_rem)
   );

   // Datapath flags
   assign n_minus_p = n_ff - p_ff;
   assign bad_in    = (n_ff <= W'(2)) || n_ff[0];
   assign p_over    = p_ff > (n_ff >> 1);
   // both tested values are at least two, so no d == v check is needed: d*d > v or a zero remainder ends a scan
   assign sq_over   = sq_ff > {1'b0, v_ff};
   assign rsp_full  = rsp_valid_ff && rsp_stall;

   // Control word fetch and branch
   always_comb begin
      cw = gbp_rom(pc_ff);
      case (cw.cond)
         C_NEVER:    take = 1'b0;
         C_ALWAYS:   take = 1'b1;
         C_NO_REQ:   take = !req_valid;
         C_BAD_IN:   take = bad_in;
         C_P_OVER:   take = p_over;
         C_SQ_OVER:  take = sq_over;
         C_DIV_BUSY: take = div_busy;
         C_REM_ZERO: take = (div_rem == '0);
         C_RSP_FULL: take = rsp_full;
         default:    take = 1'b0;
      endcase
      pc_in = take ? cw.target : pc_ff + 1'b1;
   end

   // no division once the scan of this value is over
   assign div_start = (cw.op == OP_DIV_GO) && !sq_over;
   assign req_stall = (pc_ff != S_ACCEPT);

   // Datapath operations
   always_comb begin
      n_in          = n_ff;
      p_in          = p_ff;
      v_in          = v_ff;
      d_in          = d_ff;
      sq_in         = sq_ff;
      res_small_in  = res_small_ff;
      res_large_in  = res_large_ff;
      res_status_in = res_status_ff;
      case (cw.op)
         OP_LOAD_N: begin
            n_in         = W'(req_even_value);
            p_in         = W'(2);
            res_small_in = '0;
            res_large_in = '0;
         end
         OP_SET_BAD: begin
            res_status_in = STATUS_BAD_INPUT;
         end
         OP_START_P: begin
            v_in          = p_ff;
            d_in          = W'(2);
            sq_in         = (W+1)'(4);
            res_status_in = STATUS_NO_PAIR;
         end
         OP_START_Q: begin
            v_in  = n_minus_p;
            d_in  = W'(2);
            sq_in = (W+1)'(4);
         end
         OP_NEXT_D: begin
            d_in  = d_ff + 1'b1;
            sq_in = sq_ff + {d_ff, 1'b1};
         end
         OP_INC_P: begin
            p_in = p_ff + 1'b1;
         end
         OP_SET_FOUND: begin
            res_small_in  = p_ff;
            res_large_in  = n_minus_p;
            res_status_in = STATUS_FOUND;
         end
         default: begin
         end
      endcase
   end

   // Output register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_small_in  = rsp_small_ff;
      rsp_large_in  = rsp_large_ff;
      rsp_status_in = rsp_status_ff;
      if ((cw.op == OP_EMIT) && !rsp_full) begin
         rsp_valid_in  = 1'b1;
         rsp_small_in  = 15'(res_small_ff);
         rsp_large_in  = 16'(res_large_ff);
         rsp_status_in = res_status_ff;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= S_ACCEPT;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff          <= n_in;
      p_ff          <= p_in;
      v_ff          <= v_in;
      d_ff          <= d_in;
      sq_ff         <= sq_in;
      res_small_ff  <= res_small_in;
      res_large_ff  <= res_large_in;
      res_status_ff <= res_status_in;
      rsp_small_ff  <= rsp_small_in;
      rsp_large_ff  <= rsp_large_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_small_prime = rsp_small_ff;
   assign rsp_large_prime = rsp_large_ff;
   assign rsp_status      = rsp_status_ff;

   // A result appears only from the emit step
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(pc_ff) == S_EMIT)
      else $error("result raised outside emit step");

   // Failed searches carry zero primes
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff != STATUS_FOUND) |->
         (rsp_small_ff == '0) && (rsp_large_ff == '0))
      else $error("nonzero primes on failed search");

   // The remainder unit is never restarted mid-division
   assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("divider restarted while busy");

   // A found pair never has p past n/2
   assert property (@(posedge clock) disable iff (reset)
      (pc_ff == S_FOUND) |-> p_ff <= (n_ff >> 1))
      else $error("candidate beyond half of input");

endmodule
